>>> src/dbcl_pkg.sv
package dbcl_pkg;

  // history depth: law order plus two
  localparam int TAPS = 4;
  localparam int HIDX_W = $clog2(TAPS);
  localparam int NCOEF = 2 * TAPS;
  localparam int CIDX_W = $clog2(NCOEF);

  localparam int SAMPLE_W = 16;
  localparam int COEF_W = 32;
  localparam int LIMIT_W = 15;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 18;
  localparam int MUL_B_W = 33;
  localparam int PROD_W = MUL_A_W + MUL_B_W;
  localparam int ACC_W = PROD_W + 1;
  localparam int CACC_W = 48;
  localparam int Y_W = ACC_W - 16;

  // divider: 2^28 over the numerator sum, one quotient bit per cycle
  localparam int QUO_W = 29;
  localparam int DIV_CNT_W = 5;
  localparam int DIV_D_W = 17;
  localparam int DIV_R_W = 18;

  // register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_PLANT_A1 = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PLANT_A2 = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PLANT_B1 = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PLANT_B2 = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_LIMIT = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_ALLOW_NEGATIVE = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DMUL,
    ST_DACC,
    ST_MAC,
    ST_FIN
  } state_t;

endpackage

>>> src/deadbeat_control_law.sv
// deadbeat control law: one drive transaction per error transaction
// steps: accept, then, when the coefficients are stale (after reset or a plant/limit
//   write), the divider and the derive steps; then 8 products one per cycle through
//   the shared 18x33 multiplier, the last add and the output load, which waits for
//   out_tready while out_tvalid is high; no new input is accepted before the output loads
// reset (rst_n low, synchronous): histories cleared, registers to defaults, coefs stale
module deadbeat_control_law (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [dbcl_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [dbcl_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [15:0]                        in_tdata,   // [15:0] error_sample
  // output stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [15:0]                        out_tdata,  // [15:0] drive_value
  output logic                               out_tuser   // [0] was_clamped
);

  // configuration registers
  logic signed [15:0]                       plant_a1_r, plant_a2_r;
  logic signed [15:0]                       plant_b1_r, plant_b2_r;
  logic [dbcl_pkg::LIMIT_W-1:0]             limit_r;
  logic                                     allow_neg_r;
  logic                                     coef_ready_r;

  // sequencer state
  dbcl_pkg::state_t                         state_r, state_nxt;
  logic [3:0]                               k_r, k_nxt;       // mac step 0..8
  logic [2:0]                               d_r, d_nxt;       // derive step
  logic [dbcl_pkg::DIV_CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [dbcl_pkg::DIV_R_W-1:0]             rem_r, rem_nxt;
  logic [dbcl_pkg::QUO_W-1:0]               quo_r, quo_nxt;
  logic [dbcl_pkg::DIV_D_W-1:0]             div_d_r;
  logic                                     div_neg_r, div_zero_r;
  logic signed [31:0]                       r_r, r_nxt;       // reciprocal, Q16.16

  // shared multiplier and accumulators
  logic signed [dbcl_pkg::MUL_A_W-1:0]      mul_a;
  logic signed [dbcl_pkg::MUL_B_W-1:0]      mul_b;
  logic signed [dbcl_pkg::PROD_W-1:0]       prod_r;
  logic                                     prod_en;
  logic                                     pv_r, pv_nxt;     // product pending
  logic                                     sub_r, sub_nxt;   // pending one subtracts
  logic signed [dbcl_pkg::ACC_W-1:0]        acc_r, acc_nxt;
  logic signed [dbcl_pkg::CACC_W-1:0]       cacc_r, cacc_nxt;

  // histories and coefficients (q0,p0,q1,p1,...)
  logic signed [15:0]                       ehist_r [dbcl_pkg::TAPS];
  logic signed [15:0]                       uhist_r [dbcl_pkg::TAPS];
  logic signed [dbcl_pkg::COEF_W-1:0]       coef_r  [dbcl_pkg::NCOEF];
  logic                                     coef_we;
  logic [dbcl_pkg::CIDX_W-1:0]              coef_idx;
  logic signed [dbcl_pkg::COEF_W-1:0]       coef_wdata;

  // output register
  logic                                     out_tvalid_r;
  logic [15:0]                              out_tdata_r;
  logic                                     out_tuser_r;

  logic                                     in_acc, commit, derive_done;
  logic signed [15:0]                       drive_y;
  logic                                     drive_cl;

  // derived plant terms (a is the negated denominator)
  logic signed [dbcl_pkg::MUL_A_W-1:0]      neg_a1, neg_a2, a0_m1, a1_a0, b1_b0;
  logic signed [dbcl_pkg::MUL_B_W-1:0]      lim_ext, r_ext, rf_ext;
  logic signed [16:0]                       bsum;

  // derive step schedule
  logic signed [dbcl_pkg::MUL_A_W-1:0]      sch_a;
  logic signed [dbcl_pkg::MUL_B_W-1:0]      sch_b;
  logic                                     sch_sh12, sch_first, sch_last;
  logic [dbcl_pkg::CIDX_W-1:0]              sch_dest;

  // divider datapath
  logic [dbcl_pkg::DIV_R_W-1:0]             rem_sh;
  logic                                     div_ge;

  logic signed [dbcl_pkg::CACC_W-1:0]       cterm;
  logic signed [dbcl_pkg::Y_W-1:0]          y_raw, lim_y;
  logic [dbcl_pkg::HIDX_W-1:0]              hidx;

  assign neg_a1  = -dbcl_pkg::MUL_A_W'(plant_a1_r);
  assign neg_a2  = -dbcl_pkg::MUL_A_W'(plant_a2_r);
  assign a0_m1   = neg_a1 - 18'sd4096;
  assign a1_a0   = neg_a2 - neg_a1;
  assign b1_b0   = dbcl_pkg::MUL_A_W'(plant_b2_r) - dbcl_pkg::MUL_A_W'(plant_b1_r);
  assign bsum    = 17'(plant_b1_r) + 17'(plant_b2_r);
  assign lim_ext = {18'd0, limit_r};
  assign r_ext   = dbcl_pkg::MUL_B_W'(r_r);
  assign rf_ext  = r_ext - {10'd0, limit_r, 8'd0};

  assign rem_sh = {rem_r[dbcl_pkg::DIV_R_W-2:0], (cnt_r == 5'd28)};
  assign div_ge = rem_sh >= {1'b0, div_d_r};

  assign hidx = k_r[2:1];
  assign in_tready = (state_r == dbcl_pkg::ST_IDLE);
  assign in_acc = in_tvalid && in_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // coefficient schedule: each product, its shift and where its sum lands
  always_comb begin
    sch_a     = neg_a1;
    sch_b     = lim_ext;
    sch_sh12  = 1'b0;
    sch_first = 1'b1;
    sch_last  = 1'b1;
    sch_dest  = 3'd2;
    unique case (d_r)
      3'd0: begin                         // q1 = f*(a0-1) + r
        sch_a = a0_m1;
      end
      3'd1: begin                         // p1 = f*b0
        sch_a = dbcl_pkg::MUL_A_W'(plant_b1_r);
        sch_dest = 3'd3;
      end
      3'd2: begin                         // q2, first term f*(a1-a0)
        sch_a = a1_a0;
        sch_last = 1'b0;
      end
      3'd3: begin                         // q2, second term a0*r
        sch_a = neg_a1;
        sch_b = r_ext;
        sch_sh12 = 1'b1;
        sch_first = 1'b0;
        sch_dest = 3'd4;
      end
      3'd4: begin                         // p2, first term f*(b1-b0)
        sch_a = b1_b0;
        sch_last = 1'b0;
      end
      3'd5: begin                         // p2, second term b0*r
        sch_a = dbcl_pkg::MUL_A_W'(plant_b1_r);
        sch_b = r_ext;
        sch_sh12 = 1'b1;
        sch_first = 1'b0;
        sch_dest = 3'd5;
      end
      3'd6: begin                         // q3 = a1*(r-f)
        sch_a = neg_a2;
        sch_b = rf_ext;
        sch_sh12 = 1'b1;
        sch_dest = 3'd6;
      end
      3'd7: begin                         // p3 = b1*(r-f)
        sch_a = dbcl_pkg::MUL_A_W'(plant_b2_r);
        sch_b = rf_ext;
        sch_sh12 = 1'b1;
        sch_dest = 3'd7;
      end
      default: ;
    endcase
  end

  // product term after floor shift to Q32.16
  assign cterm = sch_sh12 ? dbcl_pkg::CACC_W'(prod_r >>> 12)
                          : dbcl_pkg::CACC_W'(prod_r >>> 4);

  // drive clamp on the sum, shifted down to Q28.8
  assign y_raw = dbcl_pkg::Y_W'(acc_r >>> 16);
  assign lim_y = {21'd0, limit_r};

  always_comb begin
    drive_y  = 16'(y_raw);
    drive_cl = 1'b0;
    priority if (y_raw > lim_y) begin
      drive_y  = 16'(lim_y);
      drive_cl = 1'b1;
    end else if (allow_neg_r && (y_raw < -lim_y)) begin
      drive_y  = 16'(-lim_y);
      drive_cl = 1'b1;
    end else if (!allow_neg_r && (y_raw < 0)) begin
      drive_y  = '0;
      drive_cl = 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    k_nxt       = k_r;
    d_nxt       = d_r;
    cnt_nxt     = cnt_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    r_nxt       = r_r;
    pv_nxt      = pv_r;
    sub_nxt     = sub_r;
    acc_nxt     = acc_r;
    cacc_nxt    = cacc_r;
    prod_en     = 1'b0;
    coef_we     = 1'b0;
    coef_idx    = '0;
    coef_wdata  = '0;
    commit      = 1'b0;
    derive_done = 1'b0;
    mul_a       = sch_a;
    mul_b       = sch_b;

    unique case (state_r)
      dbcl_pkg::ST_IDLE: begin
        if (in_acc) begin
          k_nxt   = '0;
          pv_nxt  = 1'b0;
          acc_nxt = '0;
          if (coef_ready_r) begin
            state_nxt = dbcl_pkg::ST_MAC;
          end else begin
            state_nxt = dbcl_pkg::ST_DIV;
            cnt_nxt   = 5'd28;
            rem_nxt   = '0;
            quo_nxt   = '0;
          end
        end
      end

      dbcl_pkg::ST_DIV: begin
        rem_nxt = div_ge ? rem_sh - {1'b0, div_d_r} : rem_sh;
        quo_nxt = {quo_r[dbcl_pkg::QUO_W-2:0], div_ge};
        cnt_nxt = cnt_r - 5'd1;
        // fixed leading coefficients go in on the spare write slots
        if (cnt_r == 5'd28) begin
          coef_we    = 1'b1;
          coef_idx   = 3'd0;
          coef_wdata = {9'd0, limit_r, 8'd0};
        end else if (cnt_r == 5'd27) begin
          coef_we    = 1'b1;
          coef_idx   = 3'd1;
          coef_wdata = 32'sd65536;
        end
        if (cnt_r == '0) begin
          if (div_zero_r) begin
            r_nxt = 32'sh7fffffff;
          end else if (div_neg_r) begin
            r_nxt = -32'(quo_nxt);
          end else begin
            r_nxt = 32'(quo_nxt);
          end
          d_nxt     = '0;
          state_nxt = dbcl_pkg::ST_DMUL;
        end
      end

      dbcl_pkg::ST_DMUL: begin
        prod_en   = 1'b1;
        state_nxt = dbcl_pkg::ST_DACC;
      end

      dbcl_pkg::ST_DACC: begin
        if (!sch_first) begin
          cacc_nxt = cacc_r + cterm;
        end else if (d_r == '0) begin
          cacc_nxt = dbcl_pkg::CACC_W'(r_r) + cterm;
        end else begin
          cacc_nxt = cterm;
        end
        if (sch_last) begin
          coef_we  = 1'b1;
          coef_idx = sch_dest;
          priority if (cacc_nxt > 48'sd2147483647) begin
            coef_wdata = 32'sh7fffffff;
          end else if (cacc_nxt < -48'sd2147483648) begin
            coef_wdata = 32'sh80000000;
          end else begin
            coef_wdata = 32'(cacc_nxt);
          end
        end
        d_nxt = d_r + 3'd1;
        if (d_r == 3'd7) begin
          derive_done = 1'b1;
          state_nxt   = dbcl_pkg::ST_MAC;
        end else begin
          state_nxt = dbcl_pkg::ST_DMUL;
        end
      end

      dbcl_pkg::ST_MAC: begin
        // issue one product a cycle, add the previous one behind it
        mul_a = k_r[0] ? dbcl_pkg::MUL_A_W'(uhist_r[hidx])
                       : dbcl_pkg::MUL_A_W'(ehist_r[hidx]);
        mul_b = dbcl_pkg::MUL_B_W'(coef_r[k_r[2:0]]);
        if (pv_r) begin
          acc_nxt = sub_r ? acc_r - dbcl_pkg::ACC_W'(prod_r)
                          : acc_r + dbcl_pkg::ACC_W'(prod_r);
        end
        if (k_r == 4'd8) begin
          pv_nxt    = 1'b0;
          state_nxt = dbcl_pkg::ST_FIN;
        end else begin
          prod_en = 1'b1;
          pv_nxt  = 1'b1;
          sub_nxt = k_r[0];
          k_nxt   = k_r + 4'd1;
        end
      end

      dbcl_pkg::ST_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          commit    = 1'b1;
          state_nxt = dbcl_pkg::ST_IDLE;
        end
      end

      default: state_nxt = dbcl_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dbcl_pkg::ST_IDLE;
      k_r          <= '0;
      d_r          <= '0;
      cnt_r        <= '0;
      pv_r         <= 1'b0;
      sub_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
      coef_ready_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      k_r          <= k_nxt;
      d_r          <= d_nxt;
      cnt_r        <= cnt_nxt;
      pv_r         <= pv_nxt;
      sub_r        <= sub_nxt;
      out_tvalid_r <= commit || (out_tvalid_r && !out_tready);
      // plant or limit writes make the coefficients stale
      if (cfg_we && (cfg_addr == dbcl_pkg::REG_PLANT_A1 ||
                     cfg_addr == dbcl_pkg::REG_PLANT_A2 ||
                     cfg_addr == dbcl_pkg::REG_PLANT_B1 ||
                     cfg_addr == dbcl_pkg::REG_PLANT_B2 ||
                     cfg_addr == dbcl_pkg::REG_OUTPUT_LIMIT)) begin
        coef_ready_r <= 1'b0;
      end else if (derive_done) begin
        coef_ready_r <= 1'b1;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plant_a1_r  <= '0;
      plant_a2_r  <= '0;
      plant_b1_r  <= 16'sd4096;
      plant_b2_r  <= '0;
      limit_r     <= 15'd256;
      allow_neg_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        dbcl_pkg::REG_PLANT_A1:       plant_a1_r  <= cfg_wdata;
        dbcl_pkg::REG_PLANT_A2:       plant_a2_r  <= cfg_wdata;
        dbcl_pkg::REG_PLANT_B1:       plant_b1_r  <= cfg_wdata;
        dbcl_pkg::REG_PLANT_B2:       plant_b2_r  <= cfg_wdata;
        dbcl_pkg::REG_OUTPUT_LIMIT:   limit_r     <= cfg_wdata[dbcl_pkg::LIMIT_W-1:0];
        dbcl_pkg::REG_ALLOW_NEGATIVE: allow_neg_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // histories: error shifts on accept, drive shifts on output commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < dbcl_pkg::TAPS; i++) begin
        ehist_r[i] <= '0;
        uhist_r[i] <= '0;
      end
    end else begin
      if (in_acc) begin
        for (int i = dbcl_pkg::TAPS - 1; i > 0; i--) begin
          ehist_r[i] <= ehist_r[i-1];
        end
        ehist_r[0] <= in_tdata;
      end
      if (commit) begin
        for (int i = dbcl_pkg::TAPS - 1; i > 0; i--) begin
          uhist_r[i] <= uhist_r[i-1];
        end
        uhist_r[0] <= drive_y;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    r_r    <= r_nxt;
    acc_r  <= acc_nxt;
    cacc_r <= cacc_nxt;
    if (prod_en) begin
      prod_r <= dbcl_pkg::PROD_W'(mul_a) * dbcl_pkg::PROD_W'(mul_b);
    end
    if (coef_we) begin
      coef_r[coef_idx] <= coef_wdata;
    end
    // divisor magnitude and sign, latched on every input accept
    if (in_acc) begin
      div_neg_r  <= bsum[16];
      div_zero_r <= (bsum == '0);
      div_d_r    <= bsum[16] ? 17'(-bsum) : 17'(bsum);
    end
    if (commit) begin
      out_tdata_r <= drive_y;
      out_tuser_r <= drive_cl;
    end
  end

endmodule
